@@ rtl/psr_pkg.sv @@
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants for the palette sprite and primitive rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package psr_pkg;

    localparam int FB_SIDE_DEF      = 128;
    localparam int SPRITE_COUNT_DEF = 256;
    localparam int QUEUE_DEPTH      = 4;
    localparam int COORD_W          = 19;
    localparam int PAL_SIZE         = 16;
    localparam int SPRITE_DIM       = 8;

    typedef enum logic [3:0] {
        ACT_CLEAR   = 4'd0,
        ACT_PAL_SET = 4'd1,
        ACT_PAL_RST = 4'd2,
        ACT_CAMERA  = 4'd3,
        ACT_RECT    = 4'd4,
        ACT_LINE    = 4'd5,
        ACT_CIRCLE  = 4'd6,
        ACT_SPRITE  = 4'd7,
        ACT_LOAD    = 4'd8,
        ACT_READ    = 4'd9
    } action_t;

    typedef enum logic [2:0] {
        JOB_CLEAR,
        JOB_PAL_SET,
        JOB_PAL_RST,
        JOB_BOX,
        JOB_SPRITE,
        JOB_LOAD,
        JOB_READ
    } job_kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // empty: box with no pixel inside the buffer, or read outside the buffer
    typedef struct packed {
        job_kind_t   kind;
        logic        empty;
        coord_t      xa;
        coord_t      ya;
        coord_t      xb;
        coord_t      yb;
        logic [3:0]  color;
        logic [3:0]  pal_index;
        logic [7:0]  sprite;
        logic [2:0]  srow;
        logic [1:0]  flips;
        logic [31:0] word;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_BOX,
        BK_SPRITE,
        BK_READ,
        BK_READ_WAIT
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/palette_sprite_primitive_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// palette_sprite_primitive_rasterizer_unit
// 4-bit palette drawing engine: command front end, job queue, pixel engine.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle in the pixel engine.
// Reset: the frame memory is swept to zero before the first command is taken.
`default_nettype none

module palette_sprite_primitive_rasterizer_unit #(
    parameter int FB_SIDE      = psr_pkg::FB_SIDE_DEF,
    parameter int SPRITE_COUNT = psr_pkg::SPRITE_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         action,
    input  wire logic signed [15:0] x0,
    input  wire logic signed [15:0] y0,
    input  wire logic signed [15:0] x1,
    input  wire logic signed [15:0] y1,
    input  wire logic [6:0]         radius,
    input  wire logic [3:0]         color,
    input  wire logic [3:0]         pal_index,
    input  wire logic [7:0]         sprite_index,
    input  wire logic [2:0]         sprite_row,
    input  wire logic [1:0]         flips,
    input  wire logic [31:0]        sheet_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [3:0]              pixel_color
);

    logic          push, pop, full, empty, init_busy;
    psr_pkg::job_t push_job, head_job;

    psr_front #(
        .FB_SIDE      (FB_SIDE),
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .enable       (!init_busy),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .x0           (x0),
        .y0           (y0),
        .x1           (x1),
        .y1           (y1),
        .radius       (radius),
        .color        (color),
        .pal_index    (pal_index),
        .sprite_index (sprite_index),
        .sprite_row   (sprite_row),
        .flips        (flips),
        .sheet_word   (sheet_word),
        .full         (full),
        .push         (push),
        .push_job     (push_job)
    );

    psr_queue #(
        .DEPTH (psr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    psr_back #(
        .FB_SIDE      (FB_SIDE),
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head_job    (head_job),
        .pop         (pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color)
    );

    a_no_accept_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !in_ready)
        else $error("command taken during reset clearing pass");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("job popped from empty queue");

endmodule

`default_nettype wire

@@ rtl/psr_queue.sv @@
// ----------------------------------------------------------------------------
// psr_queue
// Short job queue between the command front end and the pixel engine.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_queue #(
    parameter int DEPTH = psr_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire psr_pkg::job_t push_job,
    input  wire logic         pop,
    output psr_pkg::job_t     head_job,
    output logic              full,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    psr_pkg::job_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/psr_front.sv @@
// ----------------------------------------------------------------------------
// psr_front
// Command front end: applies the camera, clips shapes to boxes, emits jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_front #(
    parameter int FB_SIDE      = psr_pkg::FB_SIDE_DEF,
    parameter int SPRITE_COUNT = psr_pkg::SPRITE_COUNT_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               enable,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [3:0]         action,
    input  wire logic signed [15:0] x0,
    input  wire logic signed [15:0] y0,
    input  wire logic signed [15:0] x1,
    input  wire logic signed [15:0] y1,
    input  wire logic [6:0]         radius,
    input  wire logic [3:0]         color,
    input  wire logic [3:0]         pal_index,
    input  wire logic [7:0]         sprite_index,
    input  wire logic [2:0]         sprite_row,
    input  wire logic [1:0]         flips,
    input  wire logic [31:0]        sheet_word,
    input  wire logic               full,
    output logic                    push,
    output psr_pkg::job_t           push_job
);

    logic signed [15:0] view_x_reg, view_y_reg;
    logic               pend_reg;
    psr_pkg::job_t      pend_job_reg;

    psr_pkg::coord_t ax, ay, bx, by, long_r, short_r, fb_max;
    psr_pkg::coord_t a_lx, a_ly, a_hx, a_hy, b_lx, b_ly, b_hx, b_hy;
    psr_pkg::coord_t ca_lx, ca_ly, ca_hx, ca_hy, cb_lx, cb_ly, cb_hx, cb_hy;
    logic            a_empty, b_empty, read_hit, sprite_ok, accept, need_push;
    psr_pkg::job_t   new_job, b_job;

    function automatic psr_pkg::coord_t clip_lo(input psr_pkg::coord_t v);
        return (v < 0) ? psr_pkg::coord_t'(0) : v;
    endfunction

    function automatic psr_pkg::coord_t clip_hi(input psr_pkg::coord_t v,
                                                input psr_pkg::coord_t m);
        return (v > m) ? m : v;
    endfunction

    assign fb_max  = psr_pkg::coord_t'(FB_SIDE - 1);
    assign ax      = psr_pkg::coord_t'(x0) - psr_pkg::coord_t'(view_x_reg);
    assign ay      = psr_pkg::coord_t'(y0) - psr_pkg::coord_t'(view_y_reg);
    assign bx      = psr_pkg::coord_t'(x1) - psr_pkg::coord_t'(view_x_reg);
    assign by      = psr_pkg::coord_t'(y1) - psr_pkg::coord_t'(view_y_reg);
    assign long_r  = (radius <= 7'd1) ? psr_pkg::coord_t'(1)
                                      : psr_pkg::coord_t'({1'b0, radius});
    assign short_r = (radius <= 7'd1) ? psr_pkg::coord_t'(0) : psr_pkg::coord_t'(1);

    // raw box bounds per shape; the circle is a cross of two boxes
    always_comb
    begin
        a_lx = ax;
        a_ly = ay;
        a_hx = bx;
        a_hy = by;
        b_lx = ax - short_r;
        b_ly = ay - long_r;
        b_hx = ax + short_r;
        b_hy = ay + long_r;
        case (psr_pkg::action_t'(action))
            psr_pkg::ACT_LINE:
            begin
                if (ax == bx)
                begin
                    a_hx = ax;
                    a_ly = (ay < by) ? ay : by;
                    a_hy = (ay < by) ? by : ay;
                end
                else
                begin
                    a_lx = (ax < bx) ? ax : bx;
                    a_hx = (ax < bx) ? bx : ax;
                    a_hy = ay;
                end
            end
            psr_pkg::ACT_CIRCLE:
            begin
                a_lx = ax - long_r;
                a_ly = ay - short_r;
                a_hx = ax + long_r;
                a_hy = ay + short_r;
            end
            default:
            begin
                a_lx = ax;
            end
        endcase
    end

    assign ca_lx   = clip_lo(a_lx);
    assign ca_ly   = clip_lo(a_ly);
    assign ca_hx   = clip_hi(a_hx, fb_max);
    assign ca_hy   = clip_hi(a_hy, fb_max);
    assign cb_lx   = clip_lo(b_lx);
    assign cb_ly   = clip_lo(b_ly);
    assign cb_hx   = clip_hi(b_hx, fb_max);
    assign cb_hy   = clip_hi(b_hy, fb_max);
    assign a_empty = (ca_lx > ca_hx) || (ca_ly > ca_hy);
    assign b_empty = (cb_lx > cb_hx) || (cb_ly > cb_hy);

    assign read_hit  = (x0 >= 0) && (psr_pkg::coord_t'(x0) <= fb_max)
                    && (y0 >= 0) && (psr_pkg::coord_t'(y0) <= fb_max);
    assign sprite_ok = (int'(sprite_index) < SPRITE_COUNT);

    always_comb
    begin
        new_job           = '0;
        new_job.color     = color;
        new_job.pal_index = pal_index;
        new_job.sprite    = sprite_index;
        new_job.srow      = sprite_row;
        new_job.flips     = flips;
        new_job.word      = sheet_word;
        need_push         = 1'b0;
        case (psr_pkg::action_t'(action))
            psr_pkg::ACT_CLEAR:
            begin
                new_job.kind = psr_pkg::JOB_CLEAR;
                need_push    = 1'b1;
            end
            psr_pkg::ACT_PAL_SET:
            begin
                new_job.kind = psr_pkg::JOB_PAL_SET;
                need_push    = 1'b1;
            end
            psr_pkg::ACT_PAL_RST:
            begin
                new_job.kind = psr_pkg::JOB_PAL_RST;
                need_push    = 1'b1;
            end
            psr_pkg::ACT_RECT, psr_pkg::ACT_LINE, psr_pkg::ACT_CIRCLE:
            begin
                new_job.kind  = psr_pkg::JOB_BOX;
                new_job.empty = a_empty;
                new_job.xa    = ca_lx;
                new_job.ya    = ca_ly;
                new_job.xb    = ca_hx;
                new_job.yb    = ca_hy;
                need_push     = 1'b1;
            end
            psr_pkg::ACT_SPRITE:
            begin
                new_job.kind = psr_pkg::JOB_SPRITE;
                new_job.xa   = ax;
                new_job.ya   = ay;
                need_push    = sprite_ok;
            end
            psr_pkg::ACT_LOAD:
            begin
                new_job.kind = psr_pkg::JOB_LOAD;
                need_push    = sprite_ok;
            end
            psr_pkg::ACT_READ:
            begin
                new_job.kind  = psr_pkg::JOB_READ;
                new_job.empty = !read_hit;
                new_job.xa    = psr_pkg::coord_t'(x0);
                new_job.ya    = psr_pkg::coord_t'(y0);
                need_push     = 1'b1;
            end
            default:
            begin
                need_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        b_job       = new_job;
        b_job.empty = b_empty;
        b_job.xa    = cb_lx;
        b_job.ya    = cb_ly;
        b_job.xb    = cb_hx;
        b_job.yb    = cb_hy;
    end

    assign in_ready = enable && !pend_reg && !full;
    assign accept   = in_valid && in_ready;
    assign push     = pend_reg ? !full : (accept && need_push);
    assign push_job = pend_reg ? pend_job_reg : new_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg <= '0;
            view_y_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (pend_reg && !full)
            begin
                pend_reg <= 1'b0;
            end
            if (accept && psr_pkg::action_t'(action) == psr_pkg::ACT_CAMERA)
            begin
                view_x_reg <= x0;
                view_y_reg <= y0;
            end
            // hold the vertical bar of a circle until the queue can take it
            if (accept && psr_pkg::action_t'(action) == psr_pkg::ACT_CIRCLE)
            begin
                pend_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_job_reg <= b_job;
        end
    end

endmodule

`default_nettype wire

@@ rtl/psr_back.sv @@
// ----------------------------------------------------------------------------
// psr_back
// Pixel engine: sweeps boxes and sprites one pixel a cycle into the frame
// memory, owns the palette and sheet memory, and answers pixel reads.
// ----------------------------------------------------------------------------
`default_nettype none

module psr_back #(
    parameter int FB_SIDE      = psr_pkg::FB_SIDE_DEF,
    parameter int SPRITE_COUNT = psr_pkg::SPRITE_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          empty,
    input  wire psr_pkg::job_t head_job,
    output logic               pop,
    output logic               init_busy,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [3:0]         pixel_color
);

    localparam int CW    = $clog2(FB_SIDE);
    localparam int FB_N  = FB_SIDE * FB_SIDE;
    localparam int AW    = $clog2(FB_N);
    localparam int SH_N  = SPRITE_COUNT * psr_pkg::SPRITE_DIM;
    localparam int SW    = $clog2(SH_N);
    localparam int LAST8 = psr_pkg::SPRITE_DIM - 1;

    logic [3:0]  frame_mem [FB_N];
    logic [31:0] sheet_mem [SH_N];

    psr_pkg::back_state_t state_reg, state_next;
    psr_pkg::job_t        cur_reg;
    logic [CW-1:0]        cx_reg, cx_next, cy_reg, cy_next;
    logic [AW-1:0]        clr_reg;
    logic                 init_reg;
    logic                 pv_reg, pspr_reg;
    logic [AW-1:0]        paddr_reg;
    logic [3:0]           pcol_reg;
    logic [2:0]           psel_reg;
    logic [31:0]          sheet_rd_reg;
    logic [3:0]           frame_rd_reg;
    logic                 out_valid_reg;
    logic [3:0]           out_data_reg;
    logic [3:0]           pal_reg [psr_pkg::PAL_SIZE];

    logic                 gen_v, gen_spr, box_last, spr_last, clr_last, rd_issue;
    logic [AW-1:0]        gen_addr, rd_addr, wr_addr;
    logic [2:0]           gen_sel, spr_row, spr_col;
    logic [SW-1:0]        sheet_raddr, sheet_waddr;
    psr_pkg::coord_t      px, py;
    logic                 px_in, py_in;
    logic [3:0]           nib, col_idx, wr_data;
    logic                 we;

    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
        return AW'(int'(y) * FB_SIDE + int'(x));
    endfunction

    assign init_busy   = init_reg;
    assign out_valid   = out_valid_reg;
    assign pixel_color = out_data_reg;

    assign box_last = (cx_reg == CW'(cur_reg.xb)) && (cy_reg == CW'(cur_reg.yb));
    assign spr_last = (cx_reg == CW'(LAST8)) && (cy_reg == CW'(LAST8));
    assign clr_last = (clr_reg == AW'(FB_N - 1));
    assign rd_issue = (state_reg == psr_pkg::BK_READ) && !out_valid_reg;

    // sprite pixel position with flips
    assign spr_col = cur_reg.flips[0] ? 3'(LAST8) - cx_reg[2:0] : cx_reg[2:0];
    assign spr_row = cur_reg.flips[1] ? 3'(LAST8) - cy_reg[2:0] : cy_reg[2:0];
    assign px      = cur_reg.xa + psr_pkg::coord_t'(cx_reg[2:0]);
    assign py      = cur_reg.ya + psr_pkg::coord_t'(cy_reg[2:0]);
    assign px_in   = (px >= 0) && (px < psr_pkg::coord_t'(FB_SIDE));
    assign py_in   = (py >= 0) && (py < psr_pkg::coord_t'(FB_SIDE));

    assign sheet_raddr = SW'((32'(cur_reg.sprite) << 3) | 32'(spr_row));
    assign sheet_waddr = SW'((32'(head_job.sprite) << 3) | 32'(head_job.srow));
    assign rd_addr     = pix_addr(CW'(cur_reg.xa), CW'(cur_reg.ya));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psr_pkg::BK_IDLE:
            begin
                if (!empty && !pv_reg)
                begin
                    case (head_job.kind)
                        psr_pkg::JOB_CLEAR:
                        begin
                            state_next = psr_pkg::BK_CLEAR;
                        end
                        psr_pkg::JOB_BOX:
                        begin
                            state_next = head_job.empty ? psr_pkg::BK_IDLE : psr_pkg::BK_BOX;
                        end
                        psr_pkg::JOB_SPRITE:
                        begin
                            state_next = psr_pkg::BK_SPRITE;
                        end
                        psr_pkg::JOB_READ:
                        begin
                            state_next = psr_pkg::BK_READ;
                        end
                        default:
                        begin
                            state_next = psr_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            psr_pkg::BK_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = psr_pkg::BK_IDLE;
                end
            end
            psr_pkg::BK_BOX:
            begin
                if (box_last)
                begin
                    state_next = psr_pkg::BK_IDLE;
                end
            end
            psr_pkg::BK_SPRITE:
            begin
                if (spr_last)
                begin
                    state_next = psr_pkg::BK_IDLE;
                end
            end
            psr_pkg::BK_READ:
            begin
                if (!out_valid_reg)
                begin
                    state_next = psr_pkg::BK_READ_WAIT;
                end
            end
            psr_pkg::BK_READ_WAIT:
            begin
                state_next = psr_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = psr_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = (state_reg == psr_pkg::BK_IDLE) && !empty && !pv_reg;
        gen_v    = 1'b0;
        gen_spr  = 1'b0;
        gen_sel  = spr_col;
        gen_addr = pix_addr(cx_reg, cy_reg);
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        case (state_reg)
            psr_pkg::BK_IDLE:
            begin
                cx_next = CW'(head_job.xa);
                cy_next = CW'(head_job.ya);
                if (head_job.kind == psr_pkg::JOB_SPRITE)
                begin
                    cx_next = '0;
                    cy_next = '0;
                end
            end
            psr_pkg::BK_BOX:
            begin
                gen_v = 1'b1;
                if (cx_reg == CW'(cur_reg.xb))
                begin
                    cx_next = CW'(cur_reg.xa);
                    cy_next = cy_reg + 1'b1;
                end
                else
                begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            psr_pkg::BK_SPRITE:
            begin
                gen_v    = px_in && py_in;
                gen_spr  = 1'b1;
                gen_addr = pix_addr(CW'(px), CW'(py));
                if (cx_reg == CW'(LAST8))
                begin
                    cx_next = '0;
                    cy_next = cy_reg + 1'b1;
                end
                else
                begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            default:
            begin
                gen_v = 1'b0;
            end
        endcase
    end

    // second stage: pick the sheet nibble, drop transparent, map through palette
    assign nib     = sheet_rd_reg[{psel_reg, 2'b00} +: 4];
    assign col_idx = pspr_reg ? nib : pcol_reg;
    assign we      = (state_reg == psr_pkg::BK_CLEAR) || (pv_reg && (!pspr_reg || nib != 4'd0));
    assign wr_addr = (state_reg == psr_pkg::BK_CLEAR) ? clr_reg : paddr_reg;
    assign wr_data = (state_reg == psr_pkg::BK_CLEAR) ? 4'd0 : pal_reg[col_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psr_pkg::BK_CLEAR;
            init_reg      <= 1'b1;
            clr_reg       <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < psr_pkg::PAL_SIZE; i++)
            begin
                pal_reg[i] <= 4'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= gen_v;
            if (state_reg == psr_pkg::BK_CLEAR)
            begin
                clr_reg <= clr_last ? '0 : clr_reg + 1'b1;
                if (clr_last)
                begin
                    init_reg <= 1'b0;
                end
            end
            if (pop && head_job.kind == psr_pkg::JOB_PAL_SET)
            begin
                pal_reg[head_job.pal_index] <= head_job.color;
            end
            if (pop && head_job.kind == psr_pkg::JOB_PAL_RST)
            begin
                for (int i = 0; i < psr_pkg::PAL_SIZE; i++)
                begin
                    pal_reg[i] <= 4'(i);
                end
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (state_reg == psr_pkg::BK_READ_WAIT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_job;
        end
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        paddr_reg <= gen_addr;
        pspr_reg  <= gen_spr;
        psel_reg  <= gen_sel;
        pcol_reg  <= cur_reg.color;
        if (state_reg == psr_pkg::BK_READ_WAIT)
        begin
            out_data_reg <= cur_reg.empty ? 4'd0 : frame_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            frame_rd_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_job.kind == psr_pkg::JOB_LOAD)
        begin
            sheet_mem[sheet_waddr] <= head_job.word;
        end
        if (state_reg == psr_pkg::BK_SPRITE)
        begin
            sheet_rd_reg <= sheet_mem[sheet_raddr];
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette sprite and primitive rasterizer. A
// driver feeds command words from a queue in random bursts. A shadow copy of
// the frame, palette, sprite sheet and camera predicts every read-back word,
// and a monitor with its own stall pattern checks each one in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE       = 128;
    localparam int SPRITES    = 256;
    localparam int IDLE_LIMIT = 400000;
    localparam int LONG_HOLD  = 4000;

    typedef struct {
        logic [3:0]         action;
        logic signed [15:0] x0;
        logic signed [15:0] y0;
        logic signed [15:0] x1;
        logic signed [15:0] y1;
        logic [6:0]         radius;
        logic [3:0]         color;
        logic [3:0]         pal_index;
        logic [7:0]         sprite_index;
        logic [2:0]         sprite_row;
        logic [1:0]         flips;
        logic [31:0]        sheet_word;
        bit                 drain_first;
    } cmd_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [3:0]         action;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic [6:0]         radius;
    logic [3:0]         color;
    logic [3:0]         pal_index;
    logic [7:0]         sprite_index;
    logic [2:0]         sprite_row;
    logic [1:0]         flips;
    logic [31:0]        sheet_word;
    logic               out_valid;
    logic               out_ready;
    logic [3:0]         pixel_color;

    // shadow state
    logic [3:0]  shadow_frame [SIDE*SIDE];
    logic [3:0]  shadow_pal [16];
    logic [31:0] shadow_sheet [SPRITES*8];
    int          cam_x;
    int          cam_y;

    cmd_t       cmd_q[$];
    logic [3:0] pending_reads[$];
    bit         failed;
    int         reads_seen;

    // generator bookkeeping: rows loaded per sprite
    logic [7:0] rows_loaded [SPRITES];
    int         full_sprites[$];

    palette_sprite_primitive_rasterizer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .x0(x0), .y0(y0), .x1(x1), .y1(y1),
        .radius(radius), .color(color), .pal_index(pal_index),
        .sprite_index(sprite_index), .sprite_row(sprite_row), .flips(flips),
        .sheet_word(sheet_word),
        .out_valid(out_valid), .out_ready(out_ready), .pixel_color(pixel_color)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic void plot_box(int xa, int ya, int xb, int yb, logic [3:0] col);
        if (xa < 0) xa = 0;
        if (ya < 0) ya = 0;
        if (xb > SIDE - 1) xb = SIDE - 1;
        if (yb > SIDE - 1) yb = SIDE - 1;
        for (int y = ya; y <= yb; y++)
            for (int x = xa; x <= xb; x++)
                shadow_frame[y*SIDE + x] = shadow_pal[col];
    endfunction

    function automatic void draw_sprite(int idx, int sx, int sy, logic [1:0] fl);
        logic [31:0] w;
        logic [3:0]  c;
        for (int y = 0; y < 8; y++)
        begin
            w = shadow_sheet[idx*8 + (fl[1] ? 7 - y : y)];
            for (int x = 0; x < 8; x++)
            begin
                c = w[4*(fl[0] ? 7 - x : x) +: 4];
                if (c != 4'd0 && sx + x >= 0 && sx + x < SIDE && sy + y >= 0 && sy + y < SIDE)
                    shadow_frame[(sy + y)*SIDE + sx + x] = shadow_pal[c];
            end
        end
    endfunction

    function automatic void apply_command(cmd_t c);
        int ax;
        int ay;
        int bx;
        int by;
        int r;
        ax = int'(c.x0) - cam_x;
        ay = int'(c.y0) - cam_y;
        bx = int'(c.x1) - cam_x;
        by = int'(c.y1) - cam_y;
        r  = int'(c.radius);
        case (c.action)
            psr_pkg::ACT_CLEAR:   foreach (shadow_frame[i]) shadow_frame[i] = 4'd0;
            psr_pkg::ACT_PAL_SET: shadow_pal[c.pal_index] = c.color;
            psr_pkg::ACT_PAL_RST: for (int i = 0; i < 16; i++) shadow_pal[i] = 4'(i);
            psr_pkg::ACT_CAMERA:
            begin
                cam_x = int'(c.x0);
                cam_y = int'(c.y0);
            end
            psr_pkg::ACT_RECT:    plot_box(ax, ay, bx, by, c.color);
            psr_pkg::ACT_LINE:
            begin
                if (ax == bx)
                    plot_box(ax, (ay < by) ? ay : by, ax, (ay < by) ? by : ay, c.color);
                else
                    plot_box((ax < bx) ? ax : bx, ay, (ax < bx) ? bx : ax, ay, c.color);
            end
            psr_pkg::ACT_CIRCLE:
            begin
                if (r <= 1)
                begin
                    plot_box(ax - 1, ay, ax + 1, ay, c.color);
                    plot_box(ax, ay - 1, ax, ay + 1, c.color);
                end
                else
                begin
                    plot_box(ax - r, ay - 1, ax + r, ay + 1, c.color);
                    plot_box(ax - 1, ay - r, ax + 1, ay + r, c.color);
                end
            end
            psr_pkg::ACT_SPRITE:  draw_sprite(int'(c.sprite_index), ax, ay, c.flips);
            psr_pkg::ACT_LOAD:
                shadow_sheet[int'(c.sprite_index)*8 + int'(c.sprite_row)] = c.sheet_word;
            psr_pkg::ACT_READ:
            begin
                if (c.x0 >= 0 && c.x0 < SIDE && c.y0 >= 0 && c.y0 < SIDE)
                    pending_reads.push_back(shadow_frame[int'(c.y0)*SIDE + int'(c.x0)]);
                else
                    pending_reads.push_back(4'd0);
            end
            default: ;
        endcase
    endfunction

    // ---------------- stimulus construction ----------------
    function automatic cmd_t blank_cmd(logic [3:0] act);
        cmd_t c;
        c.action = act;
        c.x0 = '0; c.y0 = '0; c.x1 = '0; c.y1 = '0;
        c.radius = '0; c.color = '0; c.pal_index = '0;
        c.sprite_index = '0; c.sprite_row = '0; c.flips = '0;
        c.sheet_word = '0;
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic void push_load(int spr, int row, logic [31:0] w);
        cmd_t c;
        c = blank_cmd(psr_pkg::ACT_LOAD);
        c.sprite_index = 8'(spr);
        c.sprite_row = 3'(row);
        c.sheet_word = w;
        c.color = 4'($urandom_range(0, 15));
        c.x0 = 16'($urandom);
        cmd_q.push_back(c);
        rows_loaded[spr][row] = 1'b1;
        if (rows_loaded[spr] == 8'hff && !(spr inside {full_sprites}))
            full_sprites.push_back(spr);
    endfunction

    function automatic logic [31:0] sheet_pattern();
        logic [31:0] w;
        w = $urandom;
        for (int n = 0; n < 8; n++)
            if ($urandom_range(0, 3) == 0) w[4*n +: 4] = 4'd0;
        return w;
    endfunction

    function automatic logic signed [15:0] near_coord();
        if ($urandom_range(0, 19) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 175) - 24);
    endfunction

    function automatic void push_shape(logic [3:0] act, int a, int b, int c2, int d,
                                       int rad, int col);
        cmd_t c;
        c = blank_cmd(act);
        c.x0 = 16'(a); c.y0 = 16'(b); c.x1 = 16'(c2); c.y1 = 16'(d);
        c.radius = 7'(rad);
        c.color = 4'(col);
        cmd_q.push_back(c);
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        c = blank_cmd(psr_pkg::ACT_READ);
        // random junk in every field but x1 and y1; the action decides what matters
        c.radius = 7'($urandom); c.color = 4'($urandom); c.pal_index = 4'($urandom);
        c.sprite_index = 8'($urandom); c.sprite_row = 3'($urandom);
        c.flips = 2'($urandom); c.sheet_word = $urandom;
        c.x0 = near_coord(); c.y0 = near_coord();
        pick = $urandom_range(0, 999);
        if (pick < 300)
        begin
            c.action = psr_pkg::ACT_READ;
            if ($urandom_range(0, 9) != 0)
            begin
                c.x0 = 16'($urandom_range(0, SIDE - 1));
                c.y0 = 16'($urandom_range(0, SIDE - 1));
            end
        end
        else if (pick < 450)
        begin
            c.action = psr_pkg::ACT_RECT;
            if ($urandom_range(0, 99) == 0)
            begin
                c.x1 = 16'($urandom); c.y1 = 16'($urandom);
            end
            else
            begin
                c.x1 = c.x0 + 16'($urandom_range(0, 12)) - 16'd1;
                c.y1 = c.y0 + 16'($urandom_range(0, 12)) - 16'd1;
            end
        end
        else if (pick < 560)
        begin
            c.action = psr_pkg::ACT_LINE;
            c.x1 = ($urandom_range(0, 2) == 0) ? c.x0 : near_coord();
            c.y1 = near_coord();
        end
        else if (pick < 640)
        begin
            c.action = psr_pkg::ACT_CIRCLE;
            if ($urandom_range(0, 2) != 0) c.radius = 7'($urandom_range(0, 6));
        end
        else if (pick < 780)
        begin
            c.action = psr_pkg::ACT_SPRITE;
            c.sprite_index = 8'(full_sprites[$urandom_range(0, full_sprites.size() - 1)]);
        end
        else if (pick < 880)
        begin
            c.action = psr_pkg::ACT_LOAD;
            c.sheet_word = sheet_pattern();
        end
        else if (pick < 930)
            c.action = psr_pkg::ACT_PAL_SET;
        else if (pick < 945)
            c.action = psr_pkg::ACT_PAL_RST;
        else if (pick < 975)
        begin
            c.action = psr_pkg::ACT_CAMERA;
            if ($urandom_range(0, 3) != 0)
            begin
                c.x0 = 16'($urandom_range(0, 40) - 20);
                c.y0 = 16'($urandom_range(0, 40) - 20);
            end
        end
        else if (pick < 978)
            c.action = psr_pkg::ACT_CLEAR;
        else
            c.action = 4'($urandom_range(10, 15));
        return c;
    endfunction

    initial
    begin
        cmd_t c;
        int   n;
        foreach (rows_loaded[i]) rows_loaded[i] = 8'h00;
        // directed part
        push_shape(psr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
        push_shape(psr_pkg::ACT_RECT, -5, -5, 200, 200, 0, 15);
        push_shape(psr_pkg::ACT_READ, 127, 127, 0, 0, 0, 0);
        c = blank_cmd(psr_pkg::ACT_PAL_SET); c.pal_index = 4'd15; c.color = 4'd3;
        cmd_q.push_back(c);
        push_shape(psr_pkg::ACT_LINE, 10, 40, 10, 2, 0, 15);
        push_shape(psr_pkg::ACT_LINE, 90, 7, 20, 99, 0, 9);
        push_shape(psr_pkg::ACT_RECT, 30, 30, 29, 40, 0, 1);
        push_shape(psr_pkg::ACT_CIRCLE, 0, 0, 0, 0, 0, 5);
        push_shape(psr_pkg::ACT_CIRCLE, 64, 64, 0, 0, 1, 6);
        push_shape(psr_pkg::ACT_CIRCLE, 127, 3, 0, 0, 2, 7);
        push_shape(psr_pkg::ACT_CIRCLE, 60, 70, 0, 0, 127, 8);
        for (int r = 0; r < 8; r++)
            push_load(0, r, (r == 0) ? 32'hffffffff : (r == 1) ? 32'h0 : sheet_pattern());
        for (int r = 0; r < 8; r++)
            push_load(255, r, sheet_pattern());
        for (int f = 0; f < 4; f++)
        begin
            c = blank_cmd(psr_pkg::ACT_SPRITE); c.sprite_index = (f == 3) ? 8'd255 : 8'd0;
            c.flips = 2'(f); c.x0 = 16'(f*30 - 4); c.y0 = 16'(f*30 + 123);
            cmd_q.push_back(c);
        end
        c = blank_cmd(psr_pkg::ACT_CAMERA); c.x0 = 16'sh7fff; c.y0 = 16'sh8000;
        cmd_q.push_back(c);
        push_shape(psr_pkg::ACT_RECT, -32768, 32767, 32767, -32768, 0, 2);
        push_shape(psr_pkg::ACT_LINE, 32767, -32700, 32767, -32768, 0, 4);
        push_shape(psr_pkg::ACT_READ, -1, 5, 0, 0, 0, 0);
        push_shape(psr_pkg::ACT_READ, 128, 5, 0, 0, 0, 0);
        push_shape(psr_pkg::ACT_READ, 32767, -32768, 0, 0, 0, 0);
        c = blank_cmd(psr_pkg::ACT_CAMERA); cmd_q.push_back(c);
        push_shape(psr_pkg::ACT_READ, 4, 127, 0, 0, 0, 0);
        push_shape(psr_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
        push_shape(psr_pkg::ACT_READ, 64, 64, 0, 0, 0, 0);
        c = blank_cmd(psr_pkg::ACT_PAL_RST); cmd_q.push_back(c);
        for (int a = 10; a < 16; a++)
            push_shape(4'(a), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        // random part: free commands with occasional load-then-draw sprite sequences
        n = 0;
        while (n < 1900)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                int spr;
                spr = $urandom_range(0, SPRITES - 1);
                for (int r = 0; r < 8; r++) push_load(spr, r, sheet_pattern());
                c = blank_cmd(psr_pkg::ACT_SPRITE); c.sprite_index = 8'(spr);
                c.flips = 2'($urandom); c.x0 = near_coord(); c.y0 = near_coord();
                cmd_q.push_back(c);
                n += 9;
            end
            else
            begin
                c = random_cmd();
                if (c.action == psr_pkg::ACT_LOAD)
                    push_load(int'(c.sprite_index), int'(c.sprite_row), c.sheet_word);
                else
                    cmd_q.push_back(c);
                if (c.action < 4'd10) n++;
            end
            if (n > 900 && n < 910) cmd_q[$].drain_first = 1'b1;
        end
    end

    // ---------------- reset and driver ----------------
    int burst_left;
    int gap_left;
    cmd_t cur;

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        failed = 1'b0;
        cam_x = 0;
        cam_y = 0;
        foreach (shadow_frame[i]) shadow_frame[i] = 4'd0;
        for (int i = 0; i < 16; i++) shadow_pal[i] = 4'(i);
        foreach (shadow_sheet[i]) shadow_sheet[i] = 32'd0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0; x0 <= '0; y0 <= '0; x1 <= '0; y1 <= '0;
            radius <= '0; color <= '0; pal_index <= '0; sprite_index <= '0;
            sprite_row <= '0; flips <= '0; sheet_word <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_command(cur);
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].drain_first && pending_reads.size() > 0))
                begin
                    cur = cmd_q.pop_front();
                    action <= cur.action; x0 <= cur.x0; y0 <= cur.y0;
                    x1 <= cur.x1; y1 <= cur.y1; radius <= cur.radius;
                    color <= cur.color; pal_index <= cur.pal_index;
                    sprite_index <= cur.sprite_index; sprite_row <= cur.sprite_row;
                    flips <= cur.flips; sheet_word <= cur.sheet_word;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    int hold_left;
    int stall_pct;
    int stall_age;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            reads_seen = 0;
            hold_left = 0;
            stall_pct = 0;
            stall_age = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_reads.size() == 0)
                begin
                    $display("%0t: unexpected read word, actual %0d", $time, pixel_color);
                    failed = 1'b1;
                end
                else if (pixel_color !== pending_reads[0])
                begin
                    $display("%0t: pixel_color mismatch, expected %0d actual %0d",
                             $time, pending_reads[0], pixel_color);
                    failed = 1'b1;
                    void'(pending_reads.pop_front());
                end
                else
                    void'(pending_reads.pop_front());
                reads_seen++;
                // hold off once for a long stretch so the command side backs up
                if (reads_seen == 60) hold_left = LONG_HOLD;
            end
            if (++stall_age >= 700)
            begin
                stall_age = 0;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    default: stall_pct = 80;
                endcase
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------- watchdog and end of run ----------------
    int idle_cycles;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else if (++idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (cmd_q.size() == 0);
        @(posedge clk);
        while (in_valid || pending_reads.size() > 0) @(posedge clk);
        repeat (64) @(posedge clk);
        if (!failed && pending_reads.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
